/* rtl/fss_pkg.sv */
// Package for the Fourier series synthesis block.
// Holds controller/datapath command types, states and fixed-point constants.
package fss_pkg;
	localparam logic [30:0] C1 = 31'd1686629713;
	localparam logic [29:0] C3 = 30'd693598668;
	localparam logic [29:0] C5 = 30'd85569274;
	localparam logic [29:0] C7 = 30'd5026995;
	localparam logic [29:0] C9 = 30'd172272;
	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic signed [39:0] SAT_MAX = 40'sh7FFFFFFFFF;
	localparam logic signed [39:0] SAT_MIN = -40'sh8000000000;

	localparam logic [1:0] REG_ORDER = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_STEP = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_HARM,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic start;      // latch request and start bin-0 root
		logic issue;      // issue harmonic in k_q into the pipe
		logic finish;     // saturate and load output register
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic sqrt_done;
		logic pipe_empty;
		logic oor;
	} status_t;
endpackage

/* rtl/fourier_series_synthesis.sv */
// Fourier series synthesis top level: controller plus datapath.
// Uses fss_pkg, fss_ctrl and fss_datapath.
// A load word (op 0) is taken while idle. A sample word (op 1) first runs the
// 24-step square root of bin 0, then issues harmonics 1 to harmonic_order in
// turn into the sine/cosine pipeline (none when harmonic_order is 0 or the time
// index is out of range), waits until the last product is summed, and hands the
// result off. One sample is in work at a time; a finished result waits in the
// output register while load words are still accepted, and the next sample word
// waits until that result is taken.
module fourier_series_synthesis #(
	parameter int MAX_BINS = 64,
	parameter int MAX_SAMPLES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // bin_index[5:0], bin_real[29:6], bin_imag[53:30],
	                              // time_index[69:54]
	input  logic        s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // sample_value[39:0], sample_position[55:40]
	output logic        m_tuser,  // out_of_range
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import fss_pkg::*;

	cmd_t       cmd;
	status_t    status;
	logic [5:0] k;
	logic       load;
	logic [5:0] ord_q;
	logic [16:0] cnt_q;
	logic [31:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_q <= '0;
			cnt_q <= 17'd1;
			step_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORDER: ord_q <= cfg_data[5:0];
				REG_COUNT: cnt_q <= cfg_data[16:0];
				REG_STEP: step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_op(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.harmonic_order(ord_q), .status(status), .cmd(cmd), .k(k), .load(load)
	);

	logic signed [39:0] sv;
	logic [15:0] sp;
	fss_datapath #(.MAX_BINS(MAX_BINS), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .k(k), .load(load),
		.bin_index(s_tdata[5:0]), .bin_real(s_tdata[29:6]), .bin_imag(s_tdata[53:30]),
		.time_index(s_tdata[69:54]), .sample_count(cnt_q),
		.phase_step(step_q), .sample_value(sv), .sample_position(sp),
		.out_of_range(m_tuser)
	);

	assign m_tdata = {sp, sv};
endmodule

/* rtl/fss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fss_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/fss_sine.sv */
// Pipelined Q16 sine from a 32-bit angle (full turn 2^32).
// Degree-9 Taylor polynomial in Horner form, one multiply per stage.
// Uses fss_pkg constants.
module fss_sine (
	input  logic        clk,
	input  logic [31:0] angle,
	output logic signed [17:0] sine  // registered output
);
	import fss_pkg::*;

	logic [30:0] u_s1;
	logic        neg_s1;
	logic [30:0] u_s2 [5];
	logic [30:0] u2_s2;
	logic        neg_s2 [6];
	logic [30:0] h_s [6];
	logic [30:0] u2_p [3];
	logic [16:0] mag;

	always_comb begin
		mag = 17'((32'(h_s[5]) + 32'd8192) >> 14);
	end

	always_ff @(posedge clk) begin
		u_s1 <= angle[30] ? (Q30_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
		neg_s1 <= angle[31];
		u2_s2 <= 31'((62'(u_s1) * 62'(u_s1)) >> 30);
		u_s2[0] <= u_s1;
		neg_s2[0] <= neg_s1;
		h_s[0] <= 31'(C9);
		u2_p[0] <= u2_s2;
		h_s[1] <= 31'(C7) - 31'((62'(h_s[0]) * 62'(u2_s2)) >> 30);
		u2_p[1] <= u2_p[0];
		h_s[2] <= 31'(C5) - 31'((62'(h_s[1]) * 62'(u2_p[0])) >> 30);
		u2_p[2] <= u2_p[1];
		h_s[3] <= 31'(C3) - 31'((62'(h_s[2]) * 62'(u2_p[1])) >> 30);
		h_s[4] <= C1 - 31'((62'(h_s[3]) * 62'(u2_p[2])) >> 30);
		h_s[5] <= 31'((62'(h_s[4]) * 62'(u_s2[4])) >> 30);
		for (int i = 1; i < 5; i++) begin
			u_s2[i] <= u_s2[i-1];
		end
		for (int i = 1; i < 6; i++) begin
			neg_s2[i] <= neg_s2[i-1];
		end
		sine <= neg_s2[5] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end
endmodule

/* rtl/fss_datapath.sv */
// Datapath: bin store, bin-0 square root, phase, sine/cosine pipes, accumulator.
// Uses fss_pkg, fss_ram and fss_sine.
module fss_datapath #(
	parameter int MAX_BINS = 64,
	parameter int MAX_SAMPLES = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fss_pkg::cmd_t         cmd,
	output fss_pkg::status_t      status,
	input  logic [5:0]            k,
	input  logic                  load,
	input  logic [5:0]            bin_index,
	input  logic signed [23:0]    bin_real,
	input  logic signed [23:0]    bin_imag,
	input  logic [15:0]           time_index,
	input  logic [16:0]           sample_count,
	input  logic [31:0]           phase_step,
	output logic signed [39:0]    sample_value,
	output logic [15:0]           sample_position,
	output logic                  out_of_range
);
	import fss_pkg::*;

	localparam int AW = $clog2(MAX_BINS);
	localparam int LAT = 11;

	logic [47:0]   rdata;
	logic [AW-1:0] raddr;
	logic          wr_ok;
	logic [15:0]   t_q;
	logic          oor_q;
	logic [5:0]    k_s1;
	logic          v_s1;
	logic [31:0]   kt_s2;
	logic [31:0]   th_s3;
	logic [LAT-1:0] vld_q;
	logic signed [23:0] re_d [10];
	logic signed [23:0] im_d [10];
	logic signed [17:0] cos_v, sin_v;
	logic signed [42:0] pc_s, ps_s;
	logic signed [46:0] acc_q;
	logic [47:0]   rem_q;
	logic [23:0]   root_q;
	logic [4:0]    sq_cnt_q;
	logic          sq_busy_q;
	logic signed [47:0] sq_re, sq_im;

	assign wr_ok = (32'(bin_index) < 32'(MAX_BINS));
	assign raddr = cmd.start ? AW'(0) : AW'(k);

	fss_ram #(.WIDTH(48), .DEPTH(MAX_BINS)) u_ram (
		.clk(clk), .we(load && wr_ok), .waddr(AW'(bin_index)),
		.wdata({bin_imag, bin_real}), .raddr(raddr), .rdata(rdata)
	);

	fss_sine u_cos (.clk(clk), .angle(th_s3 + 32'h40000000), .sine(cos_v));
	fss_sine u_sin (.clk(clk), .angle(th_s3), .sine(sin_v));

	// Pipe: s1 read, s2 k*t, s3 theta, then 8 sine stages, then products, then add.
	always_ff @(posedge clk) begin
		k_s1 <= k;
		kt_s2 <= 32'(k_s1) * 32'(t_q);
		th_s3 <= kt_s2 * phase_step;
		re_d[0] <= $signed(rdata[23:0]);
		im_d[0] <= $signed(rdata[47:24]);
		for (int i = 1; i < 10; i++) begin
			re_d[i] <= re_d[i-1];
			im_d[i] <= im_d[i-1];
		end
		pc_s <= 43'(re_d[9]) * 43'(cos_v);
		ps_s <= 43'(im_d[9]) * 43'(sin_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vld_q <= '0;
		end else begin
			v_s1 <= cmd.issue && (32'(k) < 32'(MAX_BINS));
			vld_q <= {vld_q[LAT-2:0], v_s1};
		end
	end

	// Bin-0 magnitude: bit-pair restoring square root, one step a cycle.
	assign sq_re = 48'($signed(rdata[23:0])) * 48'($signed(rdata[23:0]));
	assign sq_im = 48'($signed(rdata[47:24])) * 48'($signed(rdata[47:24]));

	logic [49:0] r_sh, t_sub;
	logic [47:0] src_q;
	always_comb begin
		r_sh = {rem_q, 2'b00} | 50'(src_q[47:46]);
		t_sub = {24'd0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q <= '0;
		end else if (cmd.start) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q <= 5'd0;
		end else if (!status.sqrt_done && !sq_busy_q && sq_cnt_q == 5'd0) begin
			sq_busy_q <= 1'b1;
		end else if (sq_busy_q) begin
			sq_cnt_q <= sq_cnt_q + 5'd1;
			if (sq_cnt_q == 5'd23) begin
				sq_busy_q <= 1'b0;
			end
		end
	end

	logic sq_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_done_q <= 1'b0;
		end else if (cmd.start) begin
			sq_done_q <= 1'b0;
		end else if (sq_busy_q && sq_cnt_q == 5'd23) begin
			sq_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			t_q <= time_index;
			oor_q <= ({1'b0, time_index} >= sample_count) ||
				(32'(time_index) >= 32'(MAX_SAMPLES));
		end
		if (!sq_busy_q && !sq_done_q && sq_cnt_q == 5'd0) begin
			// Read data for bin 0 sits on rdata in the cycle after start.
			src_q <= 48'(sq_re + sq_im);
			rem_q <= '0;
			root_q <= '0;
		end else if (sq_busy_q) begin
			src_q <= {src_q[45:0], 2'b00};
			if (r_sh >= t_sub) begin
				rem_q <= 48'(r_sh - t_sub);
				root_q <= {root_q[22:0], 1'b1};
			end else begin
				rem_q <= r_sh[47:0];
				root_q <= {root_q[22:0], 1'b0};
			end
		end
		if (sq_busy_q && sq_cnt_q == 5'd23) begin
			acc_q <= 47'((({1'b0, root_q, (r_sh >= t_sub)}) + 26'd1) >> 1);
		end else if (vld_q[LAT-1]) begin
			acc_q <= acc_q + 47'((pc_s + 43'sd32768) >>> 16)
				- 47'((ps_s + 43'sd32768) >>> 16);
		end
		if (cmd.finish) begin
			sample_position <= t_q;
			out_of_range <= oor_q;
			if (oor_q) begin
				sample_value <= '0;
			end else if (acc_q > 47'(SAT_MAX)) begin
				sample_value <= SAT_MAX;
			end else if (acc_q < 47'(SAT_MIN)) begin
				sample_value <= SAT_MIN;
			end else begin
				sample_value <= acc_q[39:0];
			end
		end
	end

	assign status.sqrt_done = sq_done_q;
	assign status.pipe_empty = (vld_q == '0) && !v_s1;
	assign status.oor = oor_q;
endmodule

/* rtl/fss_ctrl.sv */
// Controller state machine: sequences root, harmonic issue, drain, output.
// Uses fss_pkg.
module fss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             s_op,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  logic [5:0]       harmonic_order,
	input  fss_pkg::status_t status,
	output fss_pkg::cmd_t    cmd,
	output logic [5:0]       k,
	output logic             load
);
	import fss_pkg::*;

	state_t state_q, state_d;
	logic [5:0] k_q, k_d;
	logic       mv_q, mv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			mv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
			mv_q <= mv_d;
		end
	end

	always_comb begin
		state_d = state_q;
		k_d = k_q;
		mv_d = mv_q && !m_tready;
		cmd = '0;
		s_tready = 1'b0;
		load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// Loads go on while the previous word waits; a new request does not.
				s_tready = !(s_op && mv_q);
				if (s_tvalid && s_tready) begin
					if (!s_op) begin
						load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						k_d = 6'd1;
						state_d = ST_SQRT;
					end
				end
			end
			ST_SQRT: begin
				if (status.sqrt_done) begin
					state_d = (harmonic_order == 6'd0 || status.oor) ? ST_DRAIN : ST_HARM;
				end
			end
			ST_HARM: begin
				cmd.issue = 1'b1;
				k_d = k_q + 6'd1;
				if (k_q == harmonic_order) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.pipe_empty) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!mv_q || m_tready) begin
					cmd.finish = 1'b1;
					mv_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign k = k_q;
	assign m_tvalid = mv_q;

	ap_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> state_q == ST_IDLE) else $error("load outside idle");
	ap_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!mv_q || m_tready)) else $error("output overwritten");
	ap_issue_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> k_q != 6'd0 && k_q <= harmonic_order) else $error("bad harmonic");
endmodule
